// File: src/wbps_pkg.sv
`timescale 1ns / 1ps

package wbps_pkg;

    localparam int unsigned LEN_W    = 5;
    localparam int unsigned OFFSET_W = 32;
    localparam int unsigned WORD_W   = 64;
    localparam int unsigned ADDR_W   = 5;

    localparam logic [7:0] WILD_STAR  = 8'h2A;
    localparam logic [7:0] WILD_QUERY = 8'h3F;

    localparam logic [OFFSET_W-1:0] POS_MAX = {OFFSET_W{1'b1}};

    // register index, taken from paddr[4:3]
    localparam logic [1:0] REG_PATTERN_LOW  = 2'd0;
    localparam logic [1:0] REG_PATTERN_HIGH = 2'd1;
    localparam logic [1:0] REG_PATTERN_LEN  = 2'd2;

    typedef struct packed {
        logic [WORD_W-1:0] pattern_low;
        logic [WORD_W-1:0] pattern_high;
        logic [LEN_W-1:0]  pattern_length;
    } cfg_t;

    typedef struct packed {
        logic                emit;
        logic                found;
        logic [OFFSET_W-1:0] offset;
    } result_t;

endpackage

// File: src/wbps_if.sv
`timescale 1ns / 1ps

interface wbps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface wbps_out_if;
    logic        valid;
    logic        ready;
    logic        match_found;
    logic [31:0] match_offset;

    modport source (output valid, output match_found, output match_offset, input ready);
    modport sink (input valid, input match_found, input match_offset, output ready);
endinterface

// File: src/wbps_cfg.sv
`timescale 1ns / 1ps

module wbps_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [wbps_pkg::ADDR_W-1:0]      paddr,
    input  logic [wbps_pkg::WORD_W-1:0]      pwdata,
    output logic [wbps_pkg::WORD_W-1:0]      prdata,
    output logic                             pready,
    output wbps_pkg::cfg_t                   cfg
);
    import wbps_pkg::*;

    logic [WORD_W-1:0] low_reg;
    logic [WORD_W-1:0] high_reg;
    logic [LEN_W-1:0]  len_reg;
    logic              wr_en;
    logic [1:0]        reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= '0;
            high_reg <= '0;
            len_reg  <= LEN_W'(1);
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_PATTERN_LOW:  low_reg  <= pwdata;
                REG_PATTERN_HIGH: high_reg <= pwdata;
                REG_PATTERN_LEN:  len_reg  <= pwdata[LEN_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_PATTERN_LOW:  prdata = low_reg;
            REG_PATTERN_HIGH: prdata = high_reg;
            REG_PATTERN_LEN:  prdata = {{(WORD_W-LEN_W){1'b0}}, len_reg};
            default:          prdata = '0;
        endcase
    end

    assign cfg.pattern_low    = low_reg;
    assign cfg.pattern_high   = high_reg;
    assign cfg.pattern_length = len_reg;

endmodule

// File: src/wbps_match.sv
`timescale 1ns / 1ps

module wbps_match #(
    parameter int unsigned MAX_PATTERN_BYTES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  wbps_pkg::cfg_t    cfg,
    input  logic              step,
    input  logic [7:0]        data_byte,
    input  logic              end_of_stream,
    output wbps_pkg::result_t res
);
    import wbps_pkg::*;

    localparam int unsigned IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN_BYTES);

    logic [7:0]          window_reg [MAX_PATTERN_BYTES];
    logic [7:0]          window_next[MAX_PATTERN_BYTES];
    logic [OFFSET_W-1:0] pos_reg;
    logic                done_reg;

    logic [2*WORD_W-1:0]          needle_all;
    logic [LEN_W-1:0]             len_eff;
    logic                         saturated;
    logic [OFFSET_W-1:0]          count;
    logic [MAX_PATTERN_BYTES-1:0] byte_ok;
    logic                         hit;

    assign needle_all = {cfg.pattern_high, cfg.pattern_low};

    always_comb
    begin
        if (cfg.pattern_length == '0)
            len_eff = LEN_W'(1);
        else if (cfg.pattern_length > MAX_LEN)
            len_eff = MAX_LEN;
        else
            len_eff = cfg.pattern_length;
    end

    always_comb
    begin
        window_next[0] = data_byte;
        for (int i = 1; i < MAX_PATTERN_BYTES; i++)
            window_next[i] = window_reg[i-1];
    end

    // needle byte k lines up with window entry len-1-k (entry 0 newest)
    always_comb
    begin
        logic [7:0]       nb;
        logic [7:0]       hb;
        logic [LEN_W-1:0] sel;
        for (int k = 0; k < MAX_PATTERN_BYTES; k++)
        begin
            nb  = needle_all[8*k +: 8];
            sel = len_eff - LEN_W'(1) - LEN_W'(k);
            hb  = window_next[sel[IDX_W-1:0]];
            if (LEN_W'(k) >= len_eff)
                byte_ok[k] = 1'b1;
            else
                byte_ok[k] = (nb == WILD_STAR) || (nb == WILD_QUERY) || (nb == hb);
        end
    end

    assign saturated = (pos_reg == POS_MAX);
    assign count     = saturated ? POS_MAX : pos_reg + OFFSET_W'(1);
    assign hit       = !done_reg && (count >= {{(OFFSET_W-LEN_W){1'b0}}, len_eff}) && (&byte_ok);

    always_comb
    begin
        res.emit   = hit || (end_of_stream && !done_reg);
        res.found  = hit;
        if (!hit)
            res.offset = '0;
        else if (saturated)
            res.offset = POS_MAX;
        else
            res.offset = count - {{(OFFSET_W-LEN_W){1'b0}}, len_eff};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PATTERN_BYTES; i++)
                window_reg[i] <= '0;
            pos_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (step)
        begin
            if (end_of_stream)
            begin
                for (int i = 0; i < MAX_PATTERN_BYTES; i++)
                    window_reg[i] <= '0;
                pos_reg  <= '0;
                done_reg <= 1'b0;
            end
            else
            begin
                window_reg <= window_next;
                pos_reg    <= count;
                done_reg   <= done_reg || hit;
            end
        end
    end

endmodule

// File: src/wildcard_byte_pattern_search.sv
`timescale 1ns / 1ps
// Path: an accepted input word lands in the input register, its compare in the
// result register once that is free. The window compare is a single pass.
// Throughput: one haystack word per cycle unless an untaken result word stalls.
// Reset (rst_n low, async): pattern registers clear, length goes to 1, window,
// byte count and hit flag clear, both pipeline registers empty.

module wildcard_byte_pattern_search #(
    parameter int unsigned MAX_PATTERN_BYTES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wbps_pkg::ADDR_W-1:0]   paddr,
    input  logic [wbps_pkg::WORD_W-1:0]   pwdata,
    output logic [wbps_pkg::WORD_W-1:0]   prdata,
    output logic                          pready,
    wbps_in_if.sink                       haystack,
    wbps_out_if.source                    result
);
    import wbps_pkg::*;

    cfg_t    cfg;
    result_t res;

    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic [7:0]          s1_byte_reg;
    logic                s1_last_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_found_reg;
    logic [OFFSET_W-1:0] out_offset_reg;
    logic                out_free;
    logic                s1_adv;
    logic                in_acc;

    wbps_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wbps_match #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_match (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .step          (s1_adv),
        .data_byte     (s1_byte_reg),
        .end_of_stream (s1_last_reg),
        .res           (res)
    );

    assign out_free       = !out_valid_reg || result.ready;
    assign s1_adv         = s1_valid_reg && out_free;
    assign haystack.ready = !s1_valid_reg || out_free;
    assign in_acc         = haystack.valid && haystack.ready;

    always_comb
    begin
        if (in_acc)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s1_adv)
            out_valid_next = res.emit;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_byte_reg <= haystack.data_byte;
            s1_last_reg <= haystack.end_of_stream;
        end
        if (s1_adv && res.emit)
        begin
            out_found_reg  <= res.found;
            out_offset_reg <= res.offset;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.match_found  = out_found_reg;
    assign result.match_offset = out_offset_reg;

endmodule

// File: tb/wbps_match_checker.sv
`timescale 1ns / 1ps

module wbps_match_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [wbps_pkg::ADDR_W-1:0] paddr,
    input  logic [wbps_pkg::WORD_W-1:0] pwdata,
    wbps_in_if                          haystack,
    wbps_out_if                         result,
    output int                          mismatches,
    output int                          open_results
);

    import wbps_pkg::*;

    localparam int NEEDLE_MAX = 16;

    typedef struct packed {
        logic                found;
        logic [OFFSET_W-1:0] offset;
    } hit_report_t;

    logic [WORD_W-1:0]   needle_lo  = '0;
    logic [WORD_W-1:0]   needle_hi  = '0;
    logic [LEN_W-1:0]    needle_len = 5'd1;
    logic [7:0]          recent [NEEDLE_MAX];
    logic [OFFSET_W-1:0] byte_count = '0;
    logic                hit_seen   = 1'b0;
    hit_report_t         expected_q [$];
    int                  miss_count = 0;
    int                  waiting    = 0;

    assign mismatches   = miss_count;
    assign open_results = waiting;

    function automatic logic [7:0] needle_at(int k);
        if (k < 8)
            return needle_lo[8*k +: 8];
        return needle_hi[8*(k-8) +: 8];
    endfunction

    function automatic int clamp_len(logic [LEN_W-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > NEEDLE_MAX)
            return NEEDLE_MAX;
        return int'(raw);
    endfunction

    task automatic clear_search();
        int i;
        for (i = 0; i < NEEDLE_MAX; i++)
            recent[i] = '0;
        byte_count = '0;
        hit_seen   = 1'b0;
    endtask

    // one haystack word in, zero or one report out
    task automatic take_byte(input logic [7:0] b, input logic last);
        int                  len;
        int                  i;
        int                  k;
        logic                saturated;
        logic                hit;
        logic [OFFSET_W-1:0] count;
        hit_report_t         rep;
        len       = clamp_len(needle_len);
        saturated = (byte_count == POS_MAX);
        for (i = NEEDLE_MAX - 1; i > 0; i--)
            recent[i] = recent[i-1];
        recent[0]  = b;
        count      = saturated ? POS_MAX : byte_count + 1'b1;
        byte_count = count;
        if (!hit_seen && count >= len)
        begin
            hit = 1'b1;
            // needle byte 0 lines up with the oldest byte of the window
            for (k = 0; k < len; k++)
                if (needle_at(k) != WILD_STAR && needle_at(k) != WILD_QUERY &&
                    needle_at(k) != recent[len-1-k])
                    hit = 1'b0;
            if (hit)
            begin
                rep.found  = 1'b1;
                rep.offset = saturated ? POS_MAX : count - OFFSET_W'(len);
                expected_q.push_back(rep);
                hit_seen = 1'b1;
            end
        end
        if (last)
        begin
            if (!hit_seen)
            begin
                rep.found  = 1'b0;
                rep.offset = '0;
                expected_q.push_back(rep);
            end
            clear_search();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        hit_report_t want;
        if (!rst_n)
        begin
            needle_lo  = '0;
            needle_hi  = '0;
            needle_len = 5'd1;
            clear_search();
            expected_q.delete();
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    if (miss_count < 10)
                        $display("%0t: unexpected result word found=%0b offset=%0d",
                                 $realtime, result.match_found, result.match_offset);
                    miss_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (result.match_found !== want.found ||
                        result.match_offset !== want.offset)
                    begin
                        if (miss_count < 10)
                            $display({"%0t: result mismatch, expected found=%0b offset=%0d,",
                                      " got found=%0b offset=%0d"},
                                     $realtime, want.found, want.offset,
                                     result.match_found, result.match_offset);
                        miss_count++;
                    end
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:3])
                    REG_PATTERN_LOW:  needle_lo  = pwdata;
                    REG_PATTERN_HIGH: needle_hi  = pwdata;
                    REG_PATTERN_LEN:  needle_len = pwdata[LEN_W-1:0];
                    default:          ;
                endcase
            end
            if (haystack.valid && haystack.ready)
                take_byte(haystack.data_byte, haystack.end_of_stream);
        end
        waiting = expected_q.size();
    end

endmodule

// File: tb/tb_wildcard_byte_pattern_search.sv
`timescale 1ns / 1ps

module tb_wildcard_byte_pattern_search;

    import wbps_pkg::*;

    localparam logic [1:0] REG_UNMAPPED = 2'd3;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 4;
    localparam int ITEM_TARGET  = 1225;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [WORD_W-1:0] pwdata;
    wire  [WORD_W-1:0] prdata;
    wire               pready;

    wbps_in_if  hay_if ();
    wbps_out_if res_if ();

    int          mismatches;
    int          open_results;
    int          sent        = 0;
    int          idle_cycles = 0;
    logic        calm        = 1'b0;
    logic [63:0] cur_lo      = '0;
    logic [63:0] cur_hi      = '0;
    int          cur_len     = 1;

    wildcard_byte_pattern_search DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .haystack (hay_if),
        .result   (res_if)
    );

    wbps_match_checker match_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .haystack     (hay_if),
        .result       (res_if),
        .mismatches   (mismatches),
        .open_results (open_results)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(negedge clk)
        res_if.ready = calm || ($urandom_range(99) >= 36);

    always @(posedge clk)
    begin
        if (!rst_n || (hay_if.valid && hay_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb_wildcard_byte_pattern_search failed");
            $finish;
        end
    end

    function automatic logic [7:0] pick_byte(logic narrow);
        logic [7:0] alphabet [6];
        alphabet = '{8'h00, 8'hFF, 8'h41, 8'h42, WILD_STAR, WILD_QUERY};
        if (narrow)
            return alphabet[$urandom_range(5)];
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] needle_byte(int k);
        if (k < 8)
            return cur_lo[8*k +: 8];
        return cur_hi[8*(k-8) +: 8];
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic last);
        while (!calm && $urandom_range(99) < 36)
        begin
            hay_if.valid = 1'b0;
            @(negedge clk);
        end
        hay_if.valid         = 1'b1;
        hay_if.data_byte     = b;
        hay_if.end_of_stream = last;
        do
            @(posedge clk);
        while (!hay_if.ready);
        sent++;
        calm = (sent >= 400 && sent < 650);
        @(negedge clk);
    endtask

    // block idle: no word in flight, every report taken, pipeline flushed
    task automatic settle();
        hay_if.valid = 1'b0;
        while (open_results != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [WORD_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic load_config(input logic [63:0] lo, input logic [63:0] hi,
                               input logic [LEN_W-1:0] raw_len);
        logic [WORD_W-1:0] len_word;
        settle();
        cur_lo  = lo;
        cur_hi  = hi;
        cur_len = (raw_len == 0) ? 1 : (raw_len > 16) ? 16 : int'(raw_len);
        // only the low bits of the length word count
        len_word = {$urandom, $urandom};
        len_word[LEN_W-1:0] = raw_len;
        apb_write({REG_PATTERN_LOW, 3'b000}, lo);
        apb_write({REG_PATTERN_HIGH, 3'b000}, hi);
        apb_write({REG_PATTERN_LEN, 3'b000}, len_word);
    endtask

    // plant_at < 0: no needle copy; flip_at >= 0: corrupt that needle position
    task automatic run_stream(input int n, input int plant_at, input int flip_at,
                              input logic last, input logic narrow);
        int         i;
        int         k;
        logic [7:0] b;
        for (i = 0; i < n; i++)
        begin
            k = i - plant_at;
            if (plant_at >= 0 && k >= 0 && k < cur_len)
            begin
                b = needle_byte(k);
                if (b == WILD_STAR || b == WILD_QUERY)
                    b = pick_byte(narrow);
                if (k == flip_at)
                    b = b ^ (8'h01 << $urandom_range(7));
            end
            else
                b = pick_byte(narrow);
            push_byte(b, last && i == n - 1);
        end
    endtask

    initial
    begin
        logic [63:0]      lo;
        logic [63:0]      hi;
        logic [LEN_W-1:0] raw;
        logic [7:0]       nb;
        logic             narrow;
        int               i;
        int               s;
        int               streams;
        int               n;
        int               kind;
        int               plant;
        int               flip;

        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        hay_if.valid         = 1'b0;
        hay_if.data_byte     = '0;
        hay_if.end_of_stream = 1'b0;
        res_if.ready         = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // "ab*d": hit at 0 then final byte after hit; then a stream too short
        load_config(64'h0000_0000_642A_6261, 64'h0, 5'd4);
        push_byte(8'h61, 1'b0);
        push_byte(8'h62, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h64, 1'b0);
        push_byte(8'h61, 1'b1);
        push_byte(8'h61, 1'b0);
        push_byte(8'h64, 1'b1);

        settle();
        apb_write({REG_UNMAPPED, 3'b000}, {$urandom, $urandom});

        // length 0 acts as 1: hit on the final byte at offset 1
        load_config(64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);

        // length 31 acts as 16, leading '?', trailing '*', hit on final byte
        load_config(64'hFFFF_FFFF_FFFF_FF3F, 64'h2A00_0000_0000_0000, 5'd31);
        for (i = 0; i < 16; i++)
            push_byte((i == 0) ? 8'h00 : (i < 8) ? 8'hFF : (i < 15) ? 8'h00 : 8'hFF,
                      i == 15);

        while (sent < ITEM_TARGET)
        begin
            narrow = ($urandom_range(3) != 0);
            case ($urandom_range(9))
                0:       raw = 5'd0;
                1:       raw = 5'd16;
                2:       raw = 5'($urandom_range(31, 17));
                default: raw = 5'($urandom_range(6, 1));
            endcase
            for (i = 0; i < 16; i++)
            begin
                if ($urandom_range(4) == 0)
                    nb = $urandom_range(1) ? WILD_STAR : WILD_QUERY;
                else
                    nb = pick_byte(narrow);
                if (i < 8)
                    lo[8*i +: 8] = nb;
                else
                    hi[8*(i-8) +: 8] = nb;
            end
            if (!narrow && $urandom_range(1) == 1)
            begin
                lo = {$urandom, $urandom};
                hi = {$urandom, $urandom};
            end
            load_config(lo, hi, raw);

            streams = $urandom_range(6, 1);
            for (s = 0; s < streams; s++)
            begin
                n     = $urandom_range(cur_len + 12, 1);
                kind  = $urandom_range(9);
                plant = (kind < 8 && n >= cur_len) ? $urandom_range(n - cur_len) : -1;
                flip  = (kind == 7) ? $urandom_range(cur_len - 1) : -1;
                // an open search now and then carries over into the next setting
                run_stream(n, plant, flip, (s < streams - 1) || ($urandom_range(3) != 0),
                           narrow);
            end
        end

        settle();
        if (mismatches == 0 && open_results == 0)
            $display("tb_wildcard_byte_pattern_search passed");
        else
            $display("tb_wildcard_byte_pattern_search failed");
        $finish;
    end

endmodule
